### hdl/lobm_pkg.sv
package lobm_pkg;
   localparam int ORDER_SLOTS_DEF = 32;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;
   localparam logic [1:0] OP_EOD    = 2'd3;

   localparam logic [2:0] TYPE_GTC = 3'd0;
   localparam logic [2:0] TYPE_FAK = 3'd1;
   localparam logic [2:0] TYPE_FOK = 3'd2;
   localparam logic [2:0] TYPE_GFD = 3'd3;
   localparam logic [2:0] TYPE_MKT = 3'd4;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_DUP     = 3'd1;
   localparam logic [2:0] ST_NOLIQ   = 3'd2;
   localparam logic [2:0] ST_FAK     = 3'd3;
   localparam logic [2:0] ST_FOK     = 3'd4;
   localparam logic [2:0] ST_UNKNOWN = 3'd5;
   localparam logic [2:0] ST_FULL    = 3'd6;

   localparam logic KIND_TRADE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic scan_start;   // clear scan accumulators, restart index
      logic scan_step;    // visit one slot
      logic load_req;     // latch request
      logic kill_found;   // invalidate found id slot
      logic store_new;    // write new order into free slot
      logic apply_fill;   // subtract fill from best ask/bid
      logic kill_new;     // drop fak remainder
      logic map_market;   // replace price by worst opposite price
      logic eod_step;     // drop gfd in current slot
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic opp_any;
      logic fak_cross;
      logic fok_enough;
      logic free_any;
      logic can_trade;
      logic new_alive_fak;
      logic is_mkt;
      logic is_fak;
      logic is_fok;
   } sts_type;
endpackage

### hdl/lobm_datapath.sv
module lobm_datapath #(
   parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  lobm_pkg::cmd_type   cmd,
   output lobm_pkg::sts_type   sts,
   input  logic [31:0]         in_order_id,
   input  logic                in_side,
   input  logic [2:0]          in_order_type,
   input  logic [31:0]         in_price,
   input  logic [31:0]         in_quantity,
   output logic [31:0]         trd_ask_id,
   output logic [31:0]         trd_ask_price,
   output logic [31:0]         trd_bid_id,
   output logic [31:0]         trd_bid_price,
   output logic [31:0]         trd_quantity,
   output logic                qty_zero
);
   import lobm_pkg::*;
   localparam int IW = $clog2(ORDER_SLOTS);
   localparam int CW = $clog2(ORDER_SLOTS + 1);

   logic [ORDER_SLOTS-1:0] valid_ff, valid_in;
   logic [31:0] id_ff    [ORDER_SLOTS];
   logic        side_ff  [ORDER_SLOTS];
   logic [2:0]  kind_ff  [ORDER_SLOTS];
   logic [31:0] price_ff [ORDER_SLOTS];
   logic [31:0] rem_ff   [ORDER_SLOTS];
   logic [31:0] arr_ff   [ORDER_SLOTS];
   logic [31:0] arrival_ff;

   logic [31:0] rid_ff, rpx_ff, rqty_ff;
   logic        rside_ff;
   logic [2:0]  rtype_ff;

   logic [CW-1:0] idx_ff;
   logic [IW-1:0] idx;
   logic found_ff;
   logic [IW-1:0] found_idx_ff;
   logic free_ff;
   logic [IW-1:0] free_idx_ff;
   logic [IW-1:0] new_idx_ff;
   logic opp_any_ff;
   logic [31:0] worst_ff;
   logic ba_ok_ff, bb_ok_ff;
   logic [IW-1:0] ba_ff, bb_ff;
   logic [32:0] vol_ff;

   assign idx = idx_ff[IW-1:0];

   logic [IW-1:0] ba, bb;
   assign ba = ba_ff;
   assign bb = bb_ff;

   logic        v;
   logic        opp;
   logic        crs;
   logic [31:0] px;
   logic [31:0] age_i;
   logic        ask_better, bid_better;
   assign v   = valid_ff[idx];
   assign opp = ~rside_ff;
   assign px  = price_ff[idx];
   assign crs = rside_ff ? (px >= rpx_ff) : (px <= rpx_ff);
   assign age_i = arrival_ff - arr_ff[idx];
   assign ask_better = !ba_ok_ff || (px != price_ff[ba] ? px < price_ff[ba]
                       : age_i > (arrival_ff - arr_ff[ba]));
   assign bid_better = !bb_ok_ff || (px != price_ff[bb] ? px > price_ff[bb]
                       : age_i > (arrival_ff - arr_ff[bb]));

   logic [31:0] fill;
   assign fill = (rem_ff[ba] < rem_ff[bb]) ? rem_ff[ba] : rem_ff[bb];

   always_comb begin
      valid_in = valid_ff;
      if (cmd.kill_found) valid_in[found_idx_ff] = 1'b0;
      if (cmd.store_new) valid_in[free_idx_ff] = 1'b1;
      if (cmd.apply_fill) begin
         if (rem_ff[ba] == fill) valid_in[ba] = 1'b0;
         if (rem_ff[bb] == fill) valid_in[bb] = 1'b0;
      end
      if (cmd.kill_new) valid_in[new_idx_ff] = 1'b0;
      if (cmd.eod_step && v && kind_ff[idx] == TYPE_GFD) valid_in[idx] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         arrival_ff <= '0;
         idx_ff     <= '0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.store_new) arrival_ff <= arrival_ff + 32'd1;
         if (cmd.scan_start) idx_ff <= '0;
         else if (cmd.scan_step || cmd.eod_step) idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rid_ff   <= in_order_id;
         rside_ff <= in_side;
         rtype_ff <= (in_order_type > TYPE_MKT) ? TYPE_GTC : in_order_type;
         rpx_ff   <= in_price;
         rqty_ff  <= in_quantity;
      end
      if (cmd.map_market) begin
         rpx_ff   <= worst_ff;
         rtype_ff <= TYPE_GTC;
      end
      if (cmd.store_new) begin
         id_ff[free_idx_ff]    <= rid_ff;
         side_ff[free_idx_ff]  <= rside_ff;
         kind_ff[free_idx_ff]  <= rtype_ff;
         price_ff[free_idx_ff] <= rpx_ff;
         rem_ff[free_idx_ff]   <= rqty_ff;
         arr_ff[free_idx_ff]   <= arrival_ff;
         new_idx_ff            <= free_idx_ff;
      end
      if (cmd.apply_fill) begin
         rem_ff[ba]    <= rem_ff[ba] - fill;
         rem_ff[bb]    <= rem_ff[bb] - fill;
         trd_ask_id    <= id_ff[ba];
         trd_ask_price <= price_ff[ba];
         trd_bid_id    <= id_ff[bb];
         trd_bid_price <= price_ff[bb];
         trd_quantity  <= fill;
      end
      if (cmd.scan_start) begin
         found_ff   <= 1'b0;
         free_ff    <= 1'b0;
         opp_any_ff <= 1'b0;
         ba_ok_ff   <= 1'b0;
         bb_ok_ff   <= 1'b0;
         vol_ff     <= '0;
         found_idx_ff <= '0;
         free_idx_ff  <= '0;
         ba_ff <= '0;
         bb_ff <= '0;
         worst_ff <= '0;
      end else if (cmd.scan_step) begin
         if (v && id_ff[idx] == rid_ff && !found_ff) begin
            found_ff     <= 1'b1;
            found_idx_ff <= idx;
         end
         if (!v && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= idx;
         end
         if (v && side_ff[idx] == opp) begin
            opp_any_ff <= 1'b1;
            if (!opp_any_ff || (opp ? px > worst_ff : px < worst_ff)) worst_ff <= px;
            if (crs && !vol_ff[32]) vol_ff <= vol_ff + {1'b0, rem_ff[idx]};
         end
         if (v && side_ff[idx] && ask_better) begin
            ba_ok_ff <= 1'b1;
            ba_ff    <= idx;
         end
         if (v && !side_ff[idx] && bid_better) begin
            bb_ok_ff <= 1'b1;
            bb_ff    <= idx;
         end
      end
   end

   logic [31:0] best_opp_px;
   logic        best_opp_ok;
   assign best_opp_ok = rside_ff ? bb_ok_ff : ba_ok_ff;
   assign best_opp_px = rside_ff ? price_ff[bb] : price_ff[ba];

   assign sts.scan_done  = (idx_ff == CW'(ORDER_SLOTS - 1));
   assign sts.found      = found_ff;
   assign sts.opp_any    = opp_any_ff;
   assign sts.fak_cross  = best_opp_ok &&
      (rside_ff ? best_opp_px >= rpx_ff : best_opp_px <= rpx_ff);
   assign sts.fok_enough = vol_ff >= {1'b0, rqty_ff};
   assign sts.free_any   = free_ff;
   assign sts.can_trade  = ba_ok_ff && bb_ok_ff && (price_ff[ba] <= price_ff[bb]);
   assign sts.new_alive_fak = valid_ff[new_idx_ff] && kind_ff[new_idx_ff] == TYPE_FAK;
   assign sts.is_mkt     = (rtype_ff == TYPE_MKT);
   assign sts.is_fak     = (rtype_ff == TYPE_FAK);
   assign sts.is_fok     = (rtype_ff == TYPE_FOK);
   assign qty_zero = (rqty_ff == '0);
endmodule

### hdl/lobm_ctrl.sv
module lobm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_op,
   output lobm_pkg::cmd_type cmd,
   input  lobm_pkg::sts_type sts,
   input  logic              qty_zero,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic              rsp_kind,
   output logic [2:0]        rsp_status,
   output logic              rsp_last
);
   import lobm_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_FIND   = 10'b0000000010,
      S_CHECK  = 10'b0000000100,
      S_CHECK2 = 10'b0000001000,
      S_STORE  = 10'b0000010000,
      S_MATCH  = 10'b0000100000,
      S_DECIDE = 10'b0001000000,
      S_TRADE  = 10'b0010000000,
      S_EOD    = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic [2:0] st_ff, st_in;
   logic       valid_ff, valid_in;
   logic       kind_ff, kind_in;

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_status = (kind_ff == KIND_STATUS) ? st_ff : ST_OK;
   assign rsp_last   = kind_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      st_in    = st_ff;
      valid_in = valid_ff;
      kind_in  = kind_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req   = 1'b1;
               cmd.scan_start = 1'b1;
               op_in    = req_op;
               st_in    = ST_OK;
               state_in = (req_op == OP_EOD) ? S_EOD : S_FIND;
            end
         end
         S_FIND: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (op_ff == OP_ADD) begin
               if (sts.found) begin
                  st_in = ST_DUP; state_in = S_DONE;
               end else state_in = S_CHECK2;
            end else if (!sts.found) begin
               st_in = ST_UNKNOWN; state_in = S_DONE;
            end else begin
               cmd.kill_found = 1'b1;
               if (op_ff == OP_MODIFY) begin
                  op_in = OP_ADD;
                  cmd.scan_start = 1'b1;
                  state_in = S_FIND;
               end else state_in = S_DONE;
            end
         end
         S_CHECK2: begin
            state_in = S_DONE;
            if (sts.is_mkt) begin
               if (!sts.opp_any) st_in = ST_NOLIQ;
               else begin
                  cmd.map_market = 1'b1;
                  state_in = S_STORE;
               end
            end else if (sts.is_fak && !sts.fak_cross) st_in = ST_FAK;
            else if (sts.is_fok && !sts.fok_enough) st_in = ST_FOK;
            else state_in = S_STORE;
         end
         S_STORE: begin
            state_in = S_DONE;
            if (!qty_zero) begin
               if (!sts.free_any) st_in = ST_FULL;
               else begin
                  cmd.store_new  = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in = S_MATCH;
               end
            end
         end
         S_MATCH: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (sts.can_trade) begin
               cmd.apply_fill = 1'b1;
               state_in = S_TRADE;
            end else begin
               if (sts.new_alive_fak) cmd.kill_new = 1'b1;
               state_in = S_DONE;
            end
         end
         S_TRADE: begin
            if (!valid_ff) begin
               valid_in = 1'b1;
               kind_in  = KIND_TRADE;
            end else if (!rsp_stall) begin
               valid_in = 1'b0;
               cmd.scan_start = 1'b1;
               state_in = S_MATCH;
            end
         end
         S_EOD: begin
            cmd.eod_step = 1'b1;
            if (sts.scan_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (!valid_ff) begin
               valid_in = 1'b1;
               kind_in  = KIND_STATUS;
            end else if (!rsp_stall) begin
               valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         op_ff    <= OP_ADD;
         st_ff    <= ST_OK;
         kind_ff  <= KIND_STATUS;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         op_ff    <= op_in;
         st_ff    <= st_in;
         kind_ff  <= kind_in;
      end
   end
endmodule

### hdl/limit_order_book_matcher_core.sv
// time from accept to final result is set by serial scans of the slot table, one slot per cycle:
// cancel and end of day make a single scan, add a find scan and a match scan, modify adds
// a second find scan before those (rejected adds end after the first scan)
// each trade adds one more best-order scan and waits while rsp_stall is high
// one transaction in flight; the next is accepted in the cycle after the last result is taken
// synchronous active-high reset empties the slot table and clears the arrival counter
module limit_order_book_matcher_core #(
   parameter int ORDER_SLOTS = lobm_pkg::ORDER_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_order_id,
   input  logic        req_side,
   input  logic [2:0]  req_order_type,
   input  logic [31:0] req_price,
   input  logic [31:0] req_quantity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [31:0] rsp_ask_id,
   output logic [31:0] rsp_ask_price,
   output logic [31:0] rsp_bid_id,
   output logic [31:0] rsp_bid_price,
   output logic [31:0] rsp_fill_quantity,
   output logic [2:0]  rsp_status,
   output logic        rsp_last
);
   import lobm_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic qty_zero;
   logic [31:0] a_id, a_px, b_id, b_px, fq;

   lobm_datapath #(.ORDER_SLOTS(ORDER_SLOTS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .in_order_id(req_order_id), .in_side(req_side), .in_order_type(req_order_type),
      .in_price(req_price), .in_quantity(req_quantity),
      .trd_ask_id(a_id), .trd_ask_price(a_px), .trd_bid_id(b_id),
      .trd_bid_price(b_px), .trd_quantity(fq), .qty_zero
   );

   lobm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_op, .cmd, .sts, .qty_zero,
      .rsp_stall, .rsp_valid, .rsp_kind, .rsp_status, .rsp_last
   );

   assign rsp_ask_id        = rsp_kind ? 32'd0 : a_id;
   assign rsp_ask_price     = rsp_kind ? 32'd0 : a_px;
   assign rsp_bid_id        = rsp_kind ? 32'd0 : b_id;
   assign rsp_bid_price     = rsp_kind ? 32'd0 : b_px;
   assign rsp_fill_quantity = rsp_kind ? 32'd0 : fq;
endmodule
